// ===== rtl/tcr_pkg.sv =====
// Package for the tournament cache replacement block: action, role and policy codes,
// metadata layout constants and the victim result struct.
// Depends on nothing; used by tcr_victim and tournament_cache_replacement.
package tcr_pkg;

    localparam logic [1:0] ACT_VICTIM = 2'd0;
    localparam logic [1:0] ACT_FILL   = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;

    localparam logic [1:0] POL_LRU   = 2'd0;
    localparam logic [1:0] POL_SRRIP = 2'd1;
    localparam logic [1:0] POL_SHIP  = 2'd2;
    localparam logic [1:0] POL_NONE  = 2'd3;

    localparam logic [1:0] ROLE_FOLLOWER = 2'd3;

    localparam logic [1:0]  RRPV_MAX    = 2'd3;
    localparam logic [2:0]  CTR_MAX     = 3'd7;
    localparam logic [2:0]  CTR_INIT    = 3'd2;
    localparam logic [14:0] DECAY_RESET = 15'd32000;
    localparam logic [15:0] MISS_MAX    = 16'hFFFF;

    // Per-way metadata: [3:0] LRU age, [5:4] SRRIP RRPV, [7:6] SHiP RRPV,
    // [22:8] signature, [23] reused.
    localparam int META_W   = 24;
    localparam int SRRIP_LO = 4;
    localparam int SHIP_LO  = 6;
    localparam int SIG_LO   = 8;

    typedef struct packed {
        logic [3:0] way;
        logic [1:0] policy;
        logic       took_invalid;
        logic       aged;
    } victim_t;

endpackage

// ===== rtl/tcr_victim.sv =====
// Victim selection over one set's metadata row: invalid way search, policy choice,
// LRU search and RRIP aging. Depends on tcr_pkg.
module tcr_victim #(
    parameter int WAYS = 16
) (
    input  logic [WAYS*tcr_pkg::META_W-1:0] row,
    input  logic [15:0]                     valid_ways,
    input  logic [1:0]                      leader_role,
    input  logic [15:0]                     lru_misses,
    input  logic [15:0]                     srrip_misses,
    input  logic [15:0]                     ship_misses,
    output tcr_pkg::victim_t                res,
    output logic [WAYS*tcr_pkg::META_W-1:0] aged_row
);

    localparam int MW = tcr_pkg::META_W;

    logic [1:0] pol;
    logic [1:0] maxv;
    logic [1:0] delta;
    logic [1:0] r;
    int         shift;
    logic       found;

    always_comb
    begin
        res      = '0;
        aged_row = row;
        found    = 1'b0;
        maxv     = 2'd0;
        r        = 2'd0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!valid_ways[w])
            begin
                res.way = 4'(w);
                found   = 1'b1;
            end
        end
        // Followers use LRU unless another policy has strictly fewer misses.
        pol = leader_role;
        if (leader_role == tcr_pkg::ROLE_FOLLOWER)
        begin
            pol = tcr_pkg::POL_LRU;
            if (srrip_misses < lru_misses)
            begin
                pol = tcr_pkg::POL_SRRIP;
                if (ship_misses < srrip_misses)
                    pol = tcr_pkg::POL_SHIP;
            end
            else if (ship_misses < lru_misses)
                pol = tcr_pkg::POL_SHIP;
        end
        shift = (pol == tcr_pkg::POL_SHIP) ? tcr_pkg::SHIP_LO : tcr_pkg::SRRIP_LO;
        for (int w = 0; w < WAYS; w++)
        begin
            r = row[w*MW + shift +: 2];
            if (r > maxv)
                maxv = r;
        end
        delta = tcr_pkg::RRPV_MAX - maxv;
        if (found)
        begin
            res.policy       = tcr_pkg::POL_NONE;
            res.took_invalid = 1'b1;
        end
        else
        begin
            res.policy = pol;
            if (pol == tcr_pkg::POL_LRU)
            begin
                for (int w = WAYS - 1; w >= 0; w--)
                begin
                    if (row[w*MW +: 4] == 4'(WAYS - 1))
                        res.way = 4'(w);
                end
            end
            else
            begin
                res.aged = 1'b1;
                for (int w = 0; w < WAYS; w++)
                    aged_row[w*MW + shift +: 2] = row[w*MW + shift +: 2] + delta;
                for (int w = WAYS - 1; w >= 0; w--)
                begin
                    if (aged_row[w*MW + shift +: 2] == tcr_pkg::RRPV_MAX)
                        res.way = 4'(w);
                end
            end
        end
    end

endmodule

// ===== rtl/tournament_cache_replacement.sv =====
// Top level of the tournament cache replacement block: sequencer, set metadata memory
// and reuse counter memory. Depends on tcr_pkg and tcr_victim.
//
// The block keeps LRU, SRRIP and SHiP state for every line of a last-level cache and
// answers one transaction at a time. All per-way metadata of a set lives in one wide
// memory row (read, modified and written back whole), and the SHiP reuse counters live
// in a second memory. Both have a registered read. A victim request passes accept and
// row read before its result is registered; a hit update passes row read, counter
// index and counter read-modify-write; a fill also passes a second counter read, since
// it reads the counter of the evicted line and then the counter of the new signature
// through the same port, forwarding the first write when both index the same entry.
// Transactions that change nothing still pass through the row read. A new transaction
// is taken only once the previous one has given its result.
// After reset a clearing pass initializes every entry of both memories; no input
// transaction is taken during it, while configuration writes are.
// Each input transaction gives exactly one result, held in an output register so that
// the next transaction may be accepted while the result waits.
module tournament_cache_replacement #(
    parameter int SETS            = 2048,
    parameter int WAYS            = 16,
    parameter int COUNTER_ENTRIES = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [10:0] set_index,
    input  logic [3:0]  way,
    input  logic [1:0]  leader_role,
    input  logic [14:0] signature,
    input  logic        is_write,
    input  logic [15:0] valid_ways,
    input  logic        hit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  victim_way,
    output logic [1:0]  policy_used,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    localparam int MW        = tcr_pkg::META_W;
    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int CTR_W     = $clog2(COUNTER_ENTRIES);
    localparam int ROW_W     = WAYS * MW;
    localparam int CLR_DEPTH = (SETS > COUNTER_ENTRIES) ? SETS : COUNTER_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    // Reciprocal for the signature modulo: exact for 15-bit signatures.
    localparam int RECIP     = (2**30 + COUNTER_ENTRIES - 1) / COUNTER_ENTRIES;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINE,
        ST_CI,
        ST_CTR1,
        ST_CTR2
    } state_t;

    function automatic logic [7:0] ctr_q(input logic [14:0] s);
        logic [37:0] p;
        p = 38'(s) * 38'(RECIP);
        return p[37:30];
    endfunction

    function automatic logic [CTR_W-1:0] ctr_rem(input logic [14:0] s, input logic [7:0] q);
        logic [23:0] t;
        logic [15:0] d;
        t = 24'(q) * 24'(COUNTER_ENTRIES);
        d = {1'b0, s} - t[15:0];
        return CTR_W'(d);
    endfunction

    // Every way younger than lim grows one older; the way skip is left out.
    function automatic logic [ROW_W-1:0] age_younger(input logic [ROW_W-1:0] row,
                                                     input logic [3:0] lim,
                                                     input logic [WAY_W-1:0] skip);
        logic [3:0] a;
        for (int w = 0; w < WAYS; w++)
        begin
            a = row[w*MW +: 4];
            if (WAY_W'(w) != skip && a < lim)
                row[w*MW +: 4] = a + 4'd1;
        end
        return row;
    endfunction

    function automatic logic [ROW_W-1:0] reset_row();
        logic [ROW_W-1:0] row;
        row = '0;
        for (int w = 0; w < WAYS; w++)
            row[w*MW +: 8] = {tcr_pkg::RRPV_MAX, tcr_pkg::RRPV_MAX, 4'(w)};
        return row;
    endfunction

    state_t state_reg, state_next;

    logic [CLR_W-1:0] clr_cnt_reg;
    logic [14:0]      decay_limit_reg;
    logic [15:0]      lru_miss_reg, srrip_miss_reg, ship_miss_reg;
    logic [15:0]      lru_miss_next, srrip_miss_next, ship_miss_next;
    logic             out_valid_reg;
    logic [3:0]       victim_way_reg;
    logic [1:0]       policy_used_reg;

    logic [1:0]       action_reg;
    logic [10:0]      set_reg;
    logic [3:0]       way_reg;
    logic [1:0]       role_reg;
    logic [14:0]      sig_reg;
    logic             write_reg;
    logic [15:0]      valid_reg;
    logic             hit_reg;
    logic [7:0]       qn_reg, qo_reg;
    logic [CTR_W-1:0] nidx_reg, ci_reg;
    logic [ROW_W-1:0] row_reg;
    logic [15:0]      old_sig_reg;
    logic [2:0]       ctr_upd_reg;

    // Memories and their ports.
    logic [ROW_W-1:0] line_mem [SETS];
    logic [2:0]       ctr_mem  [COUNTER_ENTRIES];
    logic [ROW_W-1:0] line_rd;
    logic [2:0]       ctr_rd;
    logic [SET_W-1:0] line_ra, line_wa;
    logic [ROW_W-1:0] line_wd;
    logic             line_we;
    logic [CTR_W-1:0] ctr_ra, ctr_wa;
    logic [2:0]       ctr_wd;
    logic             ctr_we;

    logic             set_ok, way_ok, work_ok, out_free;
    logic [WAY_W-1:0] way_sel;
    logic [15:0]      old_sig;
    logic [CTR_W-1:0] ci;
    logic [2:0]       c2;
    logic [1:0]       srrip_ins, ship_ins;
    logic             fin;
    logic [3:0]       fin_way;
    logic [1:0]       fin_pol;
    logic [ROW_W-1:0] work_row;

    tcr_pkg::victim_t vic;
    logic [ROW_W-1:0] vic_row;

    tcr_victim #(
        .WAYS(WAYS)
    ) u_victim (
        .row          (line_rd),
        .valid_ways   (valid_reg),
        .leader_role  (role_reg),
        .lru_misses   (lru_miss_reg),
        .srrip_misses (srrip_miss_reg),
        .ship_misses  (ship_miss_reg),
        .res          (vic),
        .aged_row     (vic_row)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign victim_way  = victim_way_reg;
    assign policy_used = policy_used_reg;

    assign set_ok   = (32'(set_reg) < SETS);
    assign way_ok   = (32'(way_reg) < WAYS);
    assign work_ok  = set_ok && way_ok &&
                      ((action_reg == tcr_pkg::ACT_FILL) ||
                       (action_reg == tcr_pkg::ACT_UPDATE && hit_reg && !write_reg));
    assign out_free = !out_valid_reg || out_ready;
    assign way_sel  = way_reg[WAY_W-1:0];
    assign old_sig  = line_rd[32'(way_sel)*MW + tcr_pkg::SIG_LO +: 16];
    assign ci       = ctr_rem(old_sig_reg[14:0], qo_reg);
    // The fill's counter write in ST_CTR1 lands after the second read was issued.
    assign c2       = (nidx_reg == ci_reg) ? ctr_upd_reg : ctr_rd;

    // Miss counters: count a leader miss, then halve all three past the limit.
    always_comb
    begin
        lru_miss_next   = lru_miss_reg;
        srrip_miss_next = srrip_miss_reg;
        ship_miss_next  = ship_miss_reg;
        unique case (role_reg)
            tcr_pkg::POL_LRU:
                if (lru_miss_reg != tcr_pkg::MISS_MAX) lru_miss_next = lru_miss_reg + 16'd1;
            tcr_pkg::POL_SRRIP:
                if (srrip_miss_reg != tcr_pkg::MISS_MAX) srrip_miss_next = srrip_miss_reg + 16'd1;
            tcr_pkg::POL_SHIP:
                if (ship_miss_reg != tcr_pkg::MISS_MAX) ship_miss_next = ship_miss_reg + 16'd1;
            default:
                ;
        endcase
        if (lru_miss_next > 16'(decay_limit_reg) || srrip_miss_next > 16'(decay_limit_reg) ||
            ship_miss_next > 16'(decay_limit_reg))
        begin
            lru_miss_next   = lru_miss_next >> 1;
            srrip_miss_next = srrip_miss_next >> 1;
            ship_miss_next  = ship_miss_next >> 1;
        end
    end

    // Sequencer: memory ports, completion and next state.
    always_comb
    begin
        state_next = state_reg;
        line_ra    = (state_reg == ST_IDLE) ? SET_W'(set_index) : SET_W'(set_reg);
        line_we    = 1'b0;
        line_wa    = SET_W'(set_reg);
        line_wd    = vic_row;
        // A hit update keeps reading its own counter while it waits for the output.
        ctr_ra     = (state_reg == ST_CI) ? ci
                   : ((action_reg == tcr_pkg::ACT_FILL) ? nidx_reg : ci_reg);
        ctr_we     = 1'b0;
        ctr_wa     = ci_reg;
        ctr_wd     = ctr_rd;
        fin        = 1'b0;
        fin_way    = 4'd0;
        fin_pol    = tcr_pkg::POL_NONE;
        srrip_ins  = write_reg ? tcr_pkg::RRPV_MAX : tcr_pkg::RRPV_MAX - 2'd1;
        ship_ins   = write_reg ? tcr_pkg::RRPV_MAX
                   : ((c2 == 3'd0) ? tcr_pkg::RRPV_MAX - 2'd1 : 2'd0);
        work_row   = age_younger(row_reg, row_reg[32'(way_sel)*MW +: 4], way_sel);
        unique case (state_reg)
            ST_CLEAR:
            begin
                line_wa = SET_W'(clr_cnt_reg);
                line_wd = reset_row();
                line_we = (32'(clr_cnt_reg) < SETS);
                ctr_wa  = CTR_W'(clr_cnt_reg);
                ctr_wd  = tcr_pkg::CTR_INIT;
                ctr_we  = (32'(clr_cnt_reg) < COUNTER_ENTRIES);
                if (32'(clr_cnt_reg) == CLR_DEPTH - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (in_valid)
                    state_next = ST_LINE;
            ST_LINE:
            begin
                if (action_reg == tcr_pkg::ACT_VICTIM)
                begin
                    if (out_free)
                    begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                        if (vic.took_invalid || set_ok)
                        begin
                            fin_way = vic.way;
                            fin_pol = vic.policy;
                        end
                        line_we = set_ok && !vic.took_invalid && vic.aged;
                    end
                end
                else if (work_ok)
                    state_next = ST_CI;
                else if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CI:
                state_next = ST_CTR1;
            ST_CTR1:
            begin
                if (action_reg == tcr_pkg::ACT_FILL)
                begin
                    ctr_we     = !old_sig_reg[15] && (ctr_rd != 3'd0);
                    ctr_wd     = ctr_rd - 3'd1;
                    state_next = ST_CTR2;
                end
                else if (out_free)
                begin
                    ctr_we  = !old_sig_reg[15] && (ctr_rd != tcr_pkg::CTR_MAX);
                    ctr_wd  = ctr_rd + 3'd1;
                    line_we = 1'b1;
                    line_wd = work_row;
                    line_wd[32'(way_sel)*MW +: 8] = 8'd0;
                    line_wd[32'(way_sel)*MW + 23] = 1'b1;
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CTR2:
                if (out_free)
                begin
                    line_we = 1'b1;
                    line_wd = work_row;
                    line_wd[32'(way_sel)*MW +: MW] = {1'b0, sig_reg, ship_ins, srrip_ins, 4'd0};
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            decay_limit_reg <= tcr_pkg::DECAY_RESET;
            lru_miss_reg    <= '0;
            srrip_miss_reg  <= '0;
            ship_miss_reg   <= '0;
            out_valid_reg   <= 1'b0;
            victim_way_reg  <= '0;
            policy_used_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            if (cfg_valid)
                decay_limit_reg <= cfg_data;
            if (state_reg == ST_LINE && action_reg == tcr_pkg::ACT_FILL && work_ok)
            begin
                lru_miss_reg   <= lru_miss_next;
                srrip_miss_reg <= srrip_miss_next;
                ship_miss_reg  <= ship_miss_next;
            end
            if (fin)
            begin
                out_valid_reg   <= 1'b1;
                victim_way_reg  <= fin_way;
                policy_used_reg <= fin_pol;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Transaction payload and working registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            action_reg <= action;
            set_reg    <= set_index;
            way_reg    <= way;
            role_reg   <= leader_role;
            sig_reg    <= signature;
            write_reg  <= is_write;
            valid_reg  <= valid_ways;
            hit_reg    <= hit;
            qn_reg     <= ctr_q(signature);
        end
        if (state_reg == ST_LINE)
        begin
            row_reg     <= line_rd;
            old_sig_reg <= old_sig;
            qo_reg      <= ctr_q(old_sig[14:0]);
            nidx_reg    <= ctr_rem(sig_reg, qn_reg);
        end
        if (state_reg == ST_CI)
            ci_reg <= ci;
        if (state_reg == ST_CTR1)
            ctr_upd_reg <= ctr_we ? ctr_wd : ctr_rd;
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[line_wa] <= line_wd;
        line_rd <= line_mem[line_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ctr_we)
            ctr_mem[ctr_wa] <= ctr_wd;
        ctr_rd <= ctr_mem[ctr_ra];
    end

endmodule

// ===== tb/tcr_checker.sv =====
// Checker for the tournament cache replacement block: watches the input, result and
// configuration channels, predicts every result and compares it. Depends on tcr_pkg.
module tcr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [10:0] set_index,
    input  logic [3:0]  way,
    input  logic [1:0]  leader_role,
    input  logic [14:0] signature,
    input  logic        is_write,
    input  logic [15:0] valid_ways,
    input  logic        hit,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  victim_way,
    input  logic [1:0]  policy_used,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [14:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          checked
);

    localparam int NSETS  = 2048;
    localparam int NWAYS  = 16;
    localparam int NLINES = NSETS * NWAYS;
    localparam int NCTRS  = 32768;

    typedef struct packed {
        logic [3:0] victim;
        logic [1:0] policy;
    } replacement_t;

    // Model copy of the block's state: [3:0] age, [5:4] SRRIP, [7:6] SHiP per line.
    logic [7:0]   way_bits  [0:NLINES-1];
    logic [15:0]  way_tag   [0:NLINES-1];
    logic [2:0]   reuse_ctr [0:NCTRS-1];
    logic [15:0]  miss_lru, miss_srrip, miss_ship;
    logic [14:0]  decay_limit;
    replacement_t expected_q [$];

    task automatic clear_model();
        for (int i = 0; i < NLINES; i++) begin
            way_bits[i] = {tcr_pkg::RRPV_MAX, tcr_pkg::RRPV_MAX, 4'(i % NWAYS)};
            way_tag[i]  = '0;
        end
        for (int i = 0; i < NCTRS; i++) reuse_ctr[i] = tcr_pkg::CTR_INIT;
        miss_lru    = '0;
        miss_srrip  = '0;
        miss_ship   = '0;
        decay_limit = tcr_pkg::DECAY_RESET;
        expected_q.delete();
    endtask

    // Age one RRIP field of the set until its largest value is 3; return the first 3.
    function automatic logic [3:0] rrip_pick(int base, int lo);
        logic [1:0] top_v;
        logic [1:0] delta;
        logic [1:0] r;
        logic [3:0] pick;
        top_v = '0;
        pick  = '0;
        for (int w = 0; w < NWAYS; w++) begin
            r = way_bits[base + w][lo +: 2];
            if (r > top_v) top_v = r;
        end
        delta = tcr_pkg::RRPV_MAX - top_v;
        for (int w = 0; w < NWAYS; w++)
            way_bits[base + w][lo +: 2] = way_bits[base + w][lo +: 2] + delta;
        for (int w = NWAYS - 1; w >= 0; w--)
            if (way_bits[base + w][lo +: 2] == tcr_pkg::RRPV_MAX) pick = 4'(w);
        return pick;
    endfunction

    function automatic void age_below(int base, logic [3:0] lim, int skip);
        for (int w = 0; w < NWAYS; w++)
            if (w != skip && way_bits[base + w][3:0] < lim)
                way_bits[base + w][3:0] = way_bits[base + w][3:0] + 4'd1;
    endfunction

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v == tcr_pkg::MISS_MAX) ? v : v + 16'd1;
    endfunction

    function automatic replacement_t replace_step();
        replacement_t res;
        int           base;
        int           idx;
        logic [1:0]   pol;
        logic [15:0]  best;
        logic [15:0]  old_sig;
        logic [1:0]   srrip_ins;
        logic [1:0]   ship_ins;
        logic         found;
        res   = '{victim: 4'd0, policy: tcr_pkg::POL_NONE};
        base  = int'(set_index) * NWAYS;
        idx   = base + int'(way);
        found = 1'b0;
        if (action == tcr_pkg::ACT_VICTIM) begin
            for (int w = 0; w < NWAYS; w++)
                if (!found && !valid_ways[w]) begin
                    res.victim = 4'(w);
                    found = 1'b1;
                end
            if (!found) begin
                pol = leader_role;
                if (leader_role == tcr_pkg::ROLE_FOLLOWER) begin
                    pol  = tcr_pkg::POL_LRU;
                    best = miss_lru;
                    if (miss_srrip < best) begin
                        pol  = tcr_pkg::POL_SRRIP;
                        best = miss_srrip;
                    end
                    if (miss_ship < best) pol = tcr_pkg::POL_SHIP;
                end
                res.policy = pol;
                if (pol == tcr_pkg::POL_LRU) begin
                    for (int w = NWAYS - 1; w >= 0; w--)
                        if (way_bits[base + w][3:0] == 4'(NWAYS - 1)) res.victim = 4'(w);
                end else if (pol == tcr_pkg::POL_SRRIP) begin
                    res.victim = rrip_pick(base, tcr_pkg::SRRIP_LO);
                end else begin
                    res.victim = rrip_pick(base, tcr_pkg::SHIP_LO);
                end
            end
        end else if (action == tcr_pkg::ACT_FILL) begin
            if (leader_role == tcr_pkg::POL_LRU) miss_lru = bump(miss_lru);
            else if (leader_role == tcr_pkg::POL_SRRIP) miss_srrip = bump(miss_srrip);
            else if (leader_role == tcr_pkg::POL_SHIP) miss_ship = bump(miss_ship);
            if (miss_lru > decay_limit || miss_srrip > decay_limit || miss_ship > decay_limit)
            begin
                miss_lru   = miss_lru >> 1;
                miss_srrip = miss_srrip >> 1;
                miss_ship  = miss_ship >> 1;
            end
            // The evicted line trains its counter down unless it was ever reused.
            old_sig = way_tag[idx];
            if (!old_sig[15] && reuse_ctr[old_sig[14:0]] != 3'd0)
                reuse_ctr[old_sig[14:0]] = reuse_ctr[old_sig[14:0]] - 3'd1;
            age_below(base, way_bits[idx][3:0], int'(way));
            srrip_ins = is_write ? tcr_pkg::RRPV_MAX : tcr_pkg::RRPV_MAX - 2'd1;
            if (is_write) ship_ins = tcr_pkg::RRPV_MAX;
            else ship_ins = (reuse_ctr[signature] == 3'd0) ? tcr_pkg::RRPV_MAX - 2'd1 : 2'd0;
            way_bits[idx] = {ship_ins, srrip_ins, 4'd0};
            way_tag[idx]  = {1'b0, signature};
        end else if (action == tcr_pkg::ACT_UPDATE && hit && !is_write) begin
            old_sig = way_tag[idx];
            if (!old_sig[15]) begin
                way_tag[idx] = old_sig | 16'h8000;
                if (reuse_ctr[old_sig[14:0]] < tcr_pkg::CTR_MAX)
                    reuse_ctr[old_sig[14:0]] = reuse_ctr[old_sig[14:0]] + 3'd1;
            end
            age_below(base, way_bits[idx][3:0], NWAYS);
            way_bits[idx] = '0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        replacement_t want;
        if (!rst_n) begin
            clear_model();
            errors  <= 0;
            checked <= 0;
            pending <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result victim_way %0d policy_used %0d",
                             $time, victim_way, policy_used);
                    errors <= errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (victim_way !== want.victim || policy_used !== want.policy) begin
                        $display({"%0t: mismatch victim_way expected %0d actual %0d,",
                                  " policy_used expected %0d actual %0d"},
                                 $time, want.victim, victim_way, want.policy, policy_used);
                        errors <= errors + 1;
                    end
                    checked <= checked + 1;
                end
            end
            if (in_valid && in_ready) expected_q.push_back(replace_step());
            if (cfg_valid && cfg_ready) decay_limit = cfg_data;
            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/tb_tournament_cache_replacement.sv =====
// Testbench top for the tournament cache replacement block: clock, reset, stimulus,
// configuration phases and the verdict. Depends on tcr_pkg, the block and tcr_checker.
module tb_tournament_cache_replacement;

    // Leader roles share their codes with the policies that they lead.
    localparam logic [1:0] ROLE_LRU   = tcr_pkg::POL_LRU;
    localparam logic [1:0] ROLE_SRRIP = tcr_pkg::POL_SRRIP;
    localparam logic [1:0] ROLE_SHIP  = tcr_pkg::POL_SHIP;
    // Action code 3 is not defined by the block and must change nothing.
    localparam logic [1:0] ACT_NOP    = 2'd3;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 80;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [1:0]  leader_role;
    logic [14:0] signature;
    logic        is_write;
    logic [15:0] valid_ways;
    logic        hit;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  victim_way;
    logic [1:0]  policy_used;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;

    int errors;
    int pending;
    int checked;
    int cfg_writes;
    // When quiet is set, neither side idles. A rise of hold_requests asks the result
    // side to refuse results for a long stretch, which backs the block up.
    logic quiet;
    int   hold_requests;

    tournament_cache_replacement u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .set_index  (set_index),
        .way        (way),
        .leader_role(leader_role),
        .signature  (signature),
        .is_write   (is_write),
        .valid_ways (valid_ways),
        .hit        (hit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .victim_way (victim_way),
        .policy_used(policy_used),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    tcr_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .set_index  (set_index),
        .way        (way),
        .leader_role(leader_role),
        .signature  (signature),
        .is_write   (is_write),
        .valid_ways (valid_ways),
        .hit        (hit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .victim_way (victim_way),
        .policy_used(policy_used),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random refusals, none while quiet, and the long hold-off on request.
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 28);
        end
    end

    // Generous watchdog: the clearing pass alone walks all 32768 counter entries.
    initial
    begin
        #1000000;
        $display("tournament_cache_replacement regression: fail");
        $finish;
    end

    // One input transaction: optional idle gap, then hold valid until accepted.
    task automatic send(input logic [1:0] act, input logic [10:0] set_i, input logic [3:0] w,
                        input logic [1:0] role, input logic [14:0] sig, input logic wr,
                        input logic [15:0] vmask, input logic h);
        while (!quiet && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        set_index   <= set_i;
        way         <= w;
        leader_role <= role;
        signature   <= sig;
        is_write    <= wr;
        valid_ways  <= vmask;
        hit         <= h;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drain every outstanding result, then let the block settle before a register write.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_decay(input logic [14:0] limit);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Random traffic concentrated on a few sets and signatures so that state is reused:
    // victim requests, fills, updates (mostly hits) and undefined actions on those sets, with some noise elsewhere.
    task automatic random_traffic(input int count);
        logic [1:0]  act;
        logic [10:0] set_i;
        logic [14:0] sig;
        logic [15:0] vmask;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30) act = tcr_pkg::ACT_VICTIM;
            else if (pick < 65) act = tcr_pkg::ACT_FILL;
            else if (pick < 95) act = tcr_pkg::ACT_UPDATE;
            else act = ACT_NOP;
            set_i = ($urandom_range(99) < 75) ? 11'($urandom_range(3)) : 11'($urandom);
            sig   = ($urandom_range(99) < 60) ? 15'($urandom_range(7)) : 15'($urandom);
            vmask = ($urandom_range(99) < 80) ? 16'hFFFF : 16'($urandom);
            send(act, set_i, 4'($urandom), 2'($urandom), sig, $urandom_range(99) < 20, vmask,
                 $urandom_range(99) < 85);
        end
    endtask

    initial
    begin
        in_valid      = 1'b0;
        action        = tcr_pkg::ACT_VICTIM;
        set_index     = '0;
        way           = '0;
        leader_role   = ROLE_LRU;
        signature     = '0;
        is_write      = 1'b0;
        valid_ways    = '0;
        hit           = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        quiet         = 1'b0;
        hold_requests = 0;
        cfg_writes    = 0;
        rst_n         = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The register may be written during the clearing pass; start at its top.
        write_decay(15'h7FFF);

        // Directed part. Invalid ways win first, whatever the role.
        send(tcr_pkg::ACT_VICTIM, 11'd0, 4'd0, ROLE_LRU, 15'd0, 1'b0, 16'h0000, 1'b0);
        send(tcr_pkg::ACT_VICTIM, 11'd2047, 4'd0, ROLE_SHIP, 15'd0, 1'b0, 16'h7FFF, 1'b0);
        send(tcr_pkg::ACT_VICTIM, 11'd5, 4'd0, tcr_pkg::ROLE_FOLLOWER, 15'd0, 1'b0,
             16'hFFFE, 1'b0);
        // Full sets under each leader policy and a follower, right after reset.
        send(tcr_pkg::ACT_VICTIM, 11'd0, 4'd0, ROLE_LRU, 15'd0, 1'b0, 16'hFFFF, 1'b0);
        send(tcr_pkg::ACT_VICTIM, 11'd1, 4'd0, ROLE_SRRIP, 15'd0, 1'b0, 16'hFFFF, 1'b0);
        send(tcr_pkg::ACT_VICTIM, 11'd2, 4'd0, ROLE_SHIP, 15'd0, 1'b0, 16'hFFFF, 1'b0);
        send(tcr_pkg::ACT_VICTIM, 11'd3, 4'd0, tcr_pkg::ROLE_FOLLOWER, 15'd0, 1'b0,
             16'hFFFF, 1'b0);
        // Fills into never-used lines train counter zero down; read and write inserts.
        send(tcr_pkg::ACT_FILL, 11'd0, 4'd15, ROLE_LRU, 15'd0, 1'b0, 16'hFFFF, 1'b0);
        send(tcr_pkg::ACT_FILL, 11'd0, 4'd0, ROLE_SRRIP, 15'd0, 1'b1, 16'hFFFF, 1'b0);
        send(tcr_pkg::ACT_FILL, 11'd0, 4'd7, ROLE_SHIP, 15'h7FFF, 1'b0, 16'hFFFF, 1'b1);
        send(tcr_pkg::ACT_FILL, 11'd2047, 4'd15, tcr_pkg::ROLE_FOLLOWER, 15'h7FFF, 1'b1,
             16'hFFFF, 1'b0);
        // Hit promotes; a write or a miss on update changes nothing.
        send(tcr_pkg::ACT_UPDATE, 11'd0, 4'd7, ROLE_SHIP, 15'd0, 1'b0, 16'hFFFF, 1'b1);
        send(tcr_pkg::ACT_UPDATE, 11'd0, 4'd0, ROLE_LRU, 15'd0, 1'b1, 16'hFFFF, 1'b1);
        send(tcr_pkg::ACT_UPDATE, 11'd0, 4'd15, ROLE_LRU, 15'd0, 1'b0, 16'hFFFF, 1'b0);
        send(ACT_NOP, 11'd0, 4'd3, ROLE_SRRIP, 15'h5555, 1'b1, 16'hFFFF, 1'b1);
        // A LRU set whose oldest way was just refilled, then the RRIP policies aged.
        send(tcr_pkg::ACT_VICTIM, 11'd0, 4'd0, ROLE_LRU, 15'd0, 1'b0, 16'hFFFF, 1'b0);
        send(tcr_pkg::ACT_VICTIM, 11'd0, 4'd0, ROLE_SRRIP, 15'd0, 1'b0, 16'hFFFF, 1'b0);
        send(tcr_pkg::ACT_VICTIM, 11'd0, 4'd0, ROLE_SHIP, 15'd0, 1'b0, 16'hFFFF, 1'b0);
        send(tcr_pkg::ACT_VICTIM, 11'd0, 4'd0, tcr_pkg::ROLE_FOLLOWER, 15'd0, 1'b0,
             16'hFFFF, 1'b0);
        drain();

        // Smallest limit: the miss counters halve on almost every fill.
        write_decay(15'd1);
        random_traffic(120);
        drain();

        write_decay(15'd6);
        random_traffic(180);
        drain();

        // Last phase: a long refusal of results while items keep coming, then a
        // stretch with no idling on either side, then ordinary random idling.
        write_decay(15'($urandom_range(32767, 100)));
        hold_requests++;
        random_traffic(100);
        quiet = 1'b1;
        random_traffic(100);
        quiet = 1'b0;
        random_traffic(100);
        drain();

        $display("Checked %0d results across %0d decay limit settings,", checked, cfg_writes);
        $display("with leader, follower, fill and hit traffic under back-pressure.");
        if (errors == 0)
            $display("tournament_cache_replacement regression: pass");
        else
            $display("tournament_cache_replacement regression: fail");
        $finish;
    end

endmodule
